[src/grmq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmq_pkg
// Shared types and constants for the grid rectangle raise / max query unit.
// ----------------------------------------------------------------------------
package grmq_pkg;

	// field widths of one beat
	localparam int COORD_W    = 7;
	localparam int VAL_W      = 31;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 32;

	// bit offsets of the input fields inside s_tdata
	localparam int X_LO_LSB   = 0;
	localparam int X_HI_LSB   = X_LO_LSB + COORD_W;
	localparam int Y_LO_LSB   = X_HI_LSB + COORD_W;
	localparam int Y_HI_LSB   = Y_LO_LSB + COORD_W;
	localparam int VALUE_LSB  = Y_HI_LSB + COORD_W;
	localparam int S_USED_W   = VALUE_LSB + VAL_W;

	// operation codes carried in s_tuser
	localparam logic FUNC_RAISE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic             start;    // item accepted, clear running maximum
		logic             rd_en;    // cell read issued this cycle
		logic             clr_wr;   // clearing pass writes zero
		logic             vld_s1;   // read data of a scanned cell arrives
		logic             upd;      // current item is a raise
		logic             load_out; // move running maximum to output register
		logic [VAL_W-1:0] value;    // raise height of current item
	} ctl_t;

endpackage

[src/grmq_cell_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmq_cell_mem
// Height grid store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module grmq_cell_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [grmq_pkg::VAL_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [grmq_pkg::VAL_W-1:0] rdata_q
);

	logic [grmq_pkg::VAL_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data in the cycle after the address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

[src/grmq_max_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmq_max_unit
// Shared compare unit: larger of two heights, used for raise and for query.
// ----------------------------------------------------------------------------
module grmq_max_unit (
	input  logic [grmq_pkg::VAL_W-1:0] a,
	input  logic [grmq_pkg::VAL_W-1:0] b,
	output logic [grmq_pkg::VAL_W-1:0] y
);

	// pick the larger operand
	always_comb begin
		if (a < b) begin
			y = b;
		end else begin
			y = a;
		end
	end

endmodule

[src/grmq_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmq_seq
// Sequencer: clearing pass after reset, then a cell-by-cell rectangle scan.
// ----------------------------------------------------------------------------
module grmq_seq #(
	parameter int GRID_SIDE = 64,
	parameter int DEPTH     = 4096,
	parameter int AW        = 12,
	parameter int CW        = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_func,
	input  logic [grmq_pkg::COORD_W-1:0]  in_x_lo,
	input  logic [grmq_pkg::COORD_W-1:0]  in_x_hi,
	input  logic [grmq_pkg::COORD_W-1:0]  in_y_lo,
	input  logic [grmq_pkg::COORD_W-1:0]  in_y_hi,
	input  logic [grmq_pkg::VAL_W-1:0]    in_value,
	input  logic                          out_free,
	output grmq_pkg::ctl_t                ctl,
	output logic [AW-1:0]                 mem_raddr,
	output logic [AW-1:0]                 mem_waddr
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [AW-1:0]                clr_cnt_q;
	logic [CW-1:0]                x_q;
	logic [CW-1:0]                y_q;
	logic [CW-1:0]                x_hi_q;
	logic [CW-1:0]                y_lo_q;
	logic [CW-1:0]                y_hi_q;
	logic [AW-1:0]                row_base_q;
	logic                         func_q;
	logic [grmq_pkg::VAL_W-1:0]   value_q;
	logic                         vld_s1;
	logic [AW-1:0]                addr_s1;

	logic                         accept;
	logic [CW-1:0]                cx0;
	logic [CW-1:0]                cx1;
	logic [CW-1:0]                cy0;
	logic [CW-1:0]                cy1;
	logic                         empty;
	logic [CW-1:0]                x_nxt;
	logic [CW-1:0]                y_nxt;
	logic [AW-1:0]                scan_addr;

	// saturate a coordinate to the grid side
	function automatic logic [CW-1:0] clip(input logic [grmq_pkg::COORD_W-1:0] c);
		logic [CW-1:0] r;
		if (32'(c) > 32'(GRID_SIDE)) begin
			r = CW'(GRID_SIDE);
		end else begin
			r = CW'(c);
		end
		return r;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cx0       = clip(in_x_lo);
	assign cx1       = clip(in_x_hi);
	assign cy0       = clip(in_y_lo);
	assign cy1       = clip(in_y_hi);
	assign empty     = (cx0 >= cx1) || (cy0 >= cy1);
	assign x_nxt     = x_q + 1'b1;
	assign y_nxt     = y_q + 1'b1;
	assign scan_addr = row_base_q + AW'(y_q);

	// memory addresses: clearing pass or scanned cell
	assign mem_raddr = scan_addr;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_s1;

	// control bundle
	assign ctl.start    = accept;
	assign ctl.rd_en    = (state_q == ST_SCAN);
	assign ctl.clr_wr   = (state_q == ST_CLEAR);
	assign ctl.vld_s1   = vld_s1;
	assign ctl.upd      = (func_q == grmq_pkg::FUNC_RAISE);
	assign ctl.load_out = (state_q == ST_DRAIN) && (func_q == grmq_pkg::FUNC_QUERY) && out_free;
	assign ctl.value    = value_q;

	// state, clearing counter and scan valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= empty ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					vld_s1 <= 1'b1;
					if ((y_nxt == y_hi_q) && (x_nxt == x_hi_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// hold a query result until the output register is free
					if ((func_q == grmq_pkg::FUNC_RAISE) || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// rectangle bounds and scan position
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= in_func;
			value_q    <= in_value;
			x_q        <= cx0;
			y_q        <= cy0;
			x_hi_q     <= cx1;
			y_lo_q     <= cy0;
			y_hi_q     <= cy1;
			row_base_q <= AW'(32'(cx0) * 32'(GRID_SIDE));
		end else if (state_q == ST_SCAN) begin
			if (y_nxt == y_hi_q) begin
				y_q        <= y_lo_q;
				x_q        <= x_nxt;
				row_base_q <= row_base_q + AW'(GRID_SIDE);
			end else begin
				y_q <= y_nxt;
			end
		end
		addr_s1 <= scan_addr;
	end

endmodule

[src/grid_rectangle_max_update_query_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_rectangle_max_update_query_unit
// Rectangle raise and rectangle maximum over a square grid of heights.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_t*: s_tuser selects raise (0) or query (1), s_tdata
//   carries the half-open rectangle and the raise height. Bounds above
//   GRID_SIDE saturate; an empty or inverted range touches no cell.
//   A query gives one beat on m_t* with the rectangle maximum (0 if empty);
//   a raise gives none.
//   Cells are visited one per cycle through one read/modify/write path on the
//   grid store; s_tready stays low until an item has finished its scan and
//   drain step, also for an empty rectangle. A query result is valid on m_t*
//   in the cycle that s_tready rises again.
//   After reset the grid is cleared to zero in a pass over every cell,
//   during which s_tready stays low.
//   The result sits in an output register, so a new item may be taken while
//   it waits; a further query that finishes before it is taken holds in its
//   last step until m_tready frees the register.
// ----------------------------------------------------------------------------
module grid_rectangle_max_update_query_unit #(
	parameter int GRID_SIDE = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// x_lo[6:0], x_hi[13:7], y_lo[20:14], y_hi[27:21], value[58:28], zero pad
	input  logic [grmq_pkg::S_TDATA_W-1:0]     s_tdata,
	// func[0]
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// max_value[30:0], zero pad
	output logic [grmq_pkg::M_TDATA_W-1:0]     m_tdata
);

	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_SIDE + 1);

	grmq_pkg::ctl_t               ctl;
	logic [AW-1:0]                mem_raddr;
	logic [AW-1:0]                mem_waddr;
	logic [grmq_pkg::VAL_W-1:0]   rdata_q;
	logic [grmq_pkg::VAL_W-1:0]   mem_wdata;
	logic                         mem_we;
	logic [grmq_pkg::VAL_W-1:0]   cmp_b;
	logic [grmq_pkg::VAL_W-1:0]   cmp_y;
	logic [grmq_pkg::VAL_W-1:0]   best_q;
	logic [grmq_pkg::VAL_W-1:0]   best_nxt;
	logic                         out_valid_q;
	logic [grmq_pkg::VAL_W-1:0]   out_data_q;
	logic                         out_free;

	assign out_free = !out_valid_q || m_tready;

	grmq_seq #(
		.GRID_SIDE (GRID_SIDE),
		.DEPTH     (DEPTH),
		.AW        (AW),
		.CW        (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_func   (s_tuser),
		.in_x_lo   (s_tdata[grmq_pkg::X_LO_LSB +: grmq_pkg::COORD_W]),
		.in_x_hi   (s_tdata[grmq_pkg::X_HI_LSB +: grmq_pkg::COORD_W]),
		.in_y_lo   (s_tdata[grmq_pkg::Y_LO_LSB +: grmq_pkg::COORD_W]),
		.in_y_hi   (s_tdata[grmq_pkg::Y_HI_LSB +: grmq_pkg::COORD_W]),
		.in_value  (s_tdata[grmq_pkg::VALUE_LSB +: grmq_pkg::VAL_W]),
		.out_free  (out_free),
		.ctl       (ctl),
		.mem_raddr (mem_raddr),
		.mem_waddr (mem_waddr)
	);

	// compare the read cell with the raise height or the running maximum
	assign cmp_b = ctl.upd ? ctl.value : best_q;

	grmq_max_unit u_max (
		.a (rdata_q),
		.b (cmp_b),
		.y (cmp_y)
	);

	// write back a raised cell, or zero during the clearing pass
	assign mem_we    = ctl.clr_wr || (ctl.vld_s1 && ctl.upd);
	assign mem_wdata = ctl.clr_wr ? '0 : cmp_y;

	grmq_cell_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (ctl.rd_en),
		.raddr   (mem_raddr),
		.rdata_q (rdata_q)
	);

	// running maximum of a query
	assign best_nxt = (ctl.vld_s1 && !ctl.upd) ? cmp_y : best_q;

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			best_q <= '0;
		end else begin
			best_q <= best_nxt;
		end
	end

	// output register: load a finished query, drop it once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_data_q <= best_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(grmq_pkg::M_TDATA_W - grmq_pkg::VAL_W){1'b0}}, out_data_q};

endmodule

[tb/grmq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmq_checker
// Watches both streams of the grid unit, keeps its own height grid, predicts
// the maximum of every accepted query and compares it with the result beats.
// ----------------------------------------------------------------------------
module grmq_checker #(
	parameter int GRID_SIDE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	// x_lo[6:0], x_hi[13:7], y_lo[20:14], y_hi[27:21], value[58:28], zero pad
	input  logic [grmq_pkg::S_TDATA_W-1:0] s_tdata,
	// func[0]
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	// max_value[30:0], zero pad
	input  logic [grmq_pkg::M_TDATA_W-1:0] m_tdata,
	output int                             fail_count,
	output int                             pending_results,
	output int                             checked_results
);

	typedef struct packed {
		logic                         func;
		logic [grmq_pkg::COORD_W-1:0] x_lo;
		logic [grmq_pkg::COORD_W-1:0] x_hi;
		logic [grmq_pkg::COORD_W-1:0] y_lo;
		logic [grmq_pkg::COORD_W-1:0] y_hi;
		logic [grmq_pkg::VAL_W-1:0]   value;
	} rect_cmd_t;

	logic [grmq_pkg::VAL_W-1:0] height_model [GRID_SIDE*GRID_SIDE];
	logic [grmq_pkg::VAL_W-1:0] max_queue [$];

	// saturate a bound to the grid side
	function automatic int clip_bound(input logic [grmq_pkg::COORD_W-1:0] c);
		return (c > GRID_SIDE) ? GRID_SIDE : int'(c);
	endfunction

	task automatic report_mismatch(input string what, input logic [grmq_pkg::VAL_W-1:0] want,
			input logic [grmq_pkg::VAL_W-1:0] got);
		$display("%0t: MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
		fail_count = fail_count + 1;
	endtask

	// raise or scan the clipped rectangle; empty ranges leave the loops at once
	task automatic apply_rect(input rect_cmd_t cmd, output logic [grmq_pkg::VAL_W-1:0] best);
		int x0, x1, y0, y1;
		x0 = clip_bound(cmd.x_lo);
		x1 = clip_bound(cmd.x_hi);
		y0 = clip_bound(cmd.y_lo);
		y1 = clip_bound(cmd.y_hi);
		best = '0;
		for (int x = x0; x < x1; x++) begin
			for (int y = y0; y < y1; y++) begin
				if (cmd.func == grmq_pkg::FUNC_RAISE) begin
					if (height_model[x*GRID_SIDE + y] < cmd.value)
						height_model[x*GRID_SIDE + y] = cmd.value;
				end else if (height_model[x*GRID_SIDE + y] > best) begin
					best = height_model[x*GRID_SIDE + y];
				end
			end
		end
	endtask

	// result beat first: it always belongs to an earlier query
	always @(posedge clk) begin : watch
		rect_cmd_t                  cmd;
		logic [grmq_pkg::VAL_W-1:0] got;
		logic [grmq_pkg::VAL_W-1:0] want;
		logic [grmq_pkg::VAL_W-1:0] best;
		if (!arst_n) begin
			for (int i = 0; i < GRID_SIDE*GRID_SIDE; i++)
				height_model[i] = '0;
			max_queue.delete();
			fail_count      = 0;
			checked_results = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[grmq_pkg::VAL_W-1:0];
				if (max_queue.size() == 0) begin
					report_mismatch("result beat with no query waiting", '0, got);
				end else begin
					want = max_queue.pop_front();
					checked_results = checked_results + 1;
					if (got !== want)
						report_mismatch("max_value", want, got);
				end
			end
			if (s_tvalid && s_tready) begin
				cmd.func  = s_tuser;
				cmd.x_lo  = s_tdata[grmq_pkg::X_LO_LSB +: grmq_pkg::COORD_W];
				cmd.x_hi  = s_tdata[grmq_pkg::X_HI_LSB +: grmq_pkg::COORD_W];
				cmd.y_lo  = s_tdata[grmq_pkg::Y_LO_LSB +: grmq_pkg::COORD_W];
				cmd.y_hi  = s_tdata[grmq_pkg::Y_HI_LSB +: grmq_pkg::COORD_W];
				cmd.value = s_tdata[grmq_pkg::VALUE_LSB +: grmq_pkg::VAL_W];
				apply_rect(cmd, best);
				if (cmd.func == grmq_pkg::FUNC_QUERY)
					max_queue.push_back(best);
			end
		end
		pending_results = max_queue.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raise and query beats into the grid unit: a directed set on the
// corners, clipping and empty ranges, then random rectangles whose spans lie
// mostly in a small hot area, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int GRID_SIDE    = 64;
	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int DRAIN_CYCLES = GRID_SIDE*GRID_SIDE + 64;
	localparam int PHASE_ITEMS  = 30;
	localparam logic [grmq_pkg::VAL_W-1:0] VAL_MAX = '1;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [grmq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic                           s_tuser  = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [grmq_pkg::M_TDATA_W-1:0] m_tdata;

	int fail_count;
	int pending_results;
	int checked_results;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int raises_sent    = 0;
	int queries_sent   = 0;

	grid_rectangle_max_update_query_unit #(.GRID_SIDE(GRID_SIDE)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	grmq_checker #(.GRID_SIDE(GRID_SIDE)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_results(pending_results),
		.checked_results(checked_results)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stall the result stream at random
	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results);
			$display("simulation failed");
			$finish;
		end
	end

	// offer one beat, idling first at random, and hold it until taken
	task automatic send_rect(input logic func, input logic [6:0] xl, input logic [6:0] xh,
			input logic [6:0] yl, input logic [6:0] yh, input logic [30:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {{(grmq_pkg::S_TDATA_W-grmq_pkg::S_USED_W){1'b0}}, v, yh, yl, xh, xl};
		do @(posedge clk); while (!s_tready);
		if (func == grmq_pkg::FUNC_QUERY)
			queries_sent++;
		else
			raises_sent++;
	endtask

	// drop valid and hold off until every query has answered
	task automatic hold_until_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
	endtask

	// one axis of a random rectangle: mostly a small span in the hot corner
	task automatic pick_span(output logic [6:0] lo, output logic [6:0] hi);
		int mode, base, len;
		mode = $urandom_range(0, 99);
		if (mode < 65) begin
			base = $urandom_range(0, 12);
			len  = $urandom_range(0, 6);
			lo   = 7'(base);
			hi   = 7'(base + len);
		end else if (mode < 80) begin
			// around the far edge, often past it
			base = $urandom_range(54, 70);
			len  = $urandom_range(0, 10);
			lo   = 7'(base);
			hi   = (base + len > 127) ? 7'd127 : 7'(base + len);
		end else if (mode < 90) begin
			lo = 7'($urandom_range(0, 127));
			hi = 7'($urandom_range(0, 127));
		end else if (mode < 96) begin
			lo = 7'd0;
			hi = $urandom_range(0, 1) ? 7'd64 : 7'd127;
		end else begin
			// inverted range
			lo = 7'($urandom_range(1, 127));
			hi = 7'($urandom_range(0, lo - 1));
		end
	endtask

	function automatic logic [30:0] pick_height();
		int mode;
		mode = $urandom_range(0, 99);
		if (mode < 50)
			return 31'($urandom_range(0, 4000));
		else if (mode < 90)
			return 31'($urandom & VAL_MAX);
		else if (mode < 95)
			return VAL_MAX;
		return '0;
	endfunction

	task automatic send_random_rect();
		logic [6:0] xl, xh, yl, yh;
		logic       func;
		pick_span(xl, xh);
		pick_span(yl, yh);
		func = ($urandom_range(0, 99) < 45) ? grmq_pkg::FUNC_QUERY : grmq_pkg::FUNC_RAISE;
		send_rect(func, xl, xh, yl, yh, pick_height());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty grid, corners, clipping, empty and inverted ranges
		send_rect(grmq_pkg::FUNC_QUERY, 0, 64, 0, 64, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 0, 64, 0, 64, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 0, 1, 0, 1, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 0, 1, 0, 1, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 63, 64, 63, 64, 1);
		send_rect(grmq_pkg::FUNC_QUERY, 63, 127, 63, 127, 0);
		send_rect(grmq_pkg::FUNC_QUERY, 64, 127, 0, 64, VAL_MAX);
		send_rect(grmq_pkg::FUNC_RAISE, 10, 5, 0, 64, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 5, 10, 0, 64, VAL_MAX);
		send_rect(grmq_pkg::FUNC_RAISE, 0, 64, 40, 20, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 1, 64, 0, 64, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 30, 30, 0, 64, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 30, 31, 0, 64, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 2, 6, 3, 9, 1000);
		send_rect(grmq_pkg::FUNC_RAISE, 4, 8, 5, 7, 500);
		send_rect(grmq_pkg::FUNC_QUERY, 4, 8, 5, 7, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 4, 8, 5, 7, 2000);
		send_rect(grmq_pkg::FUNC_QUERY, 2, 8, 3, 9, 0);
		send_rect(grmq_pkg::FUNC_QUERY, 2, 4, 3, 9, 0);
		send_rect(grmq_pkg::FUNC_RAISE, 100, 127, 100, 127, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 127, 127, 127, 127, VAL_MAX);
		send_rect(grmq_pkg::FUNC_QUERY, 0, 127, 0, 127, 0);
		hold_until_drained();

		// random rectangles under each idle and stall mix
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random_rect();
			hold_until_drained();
		end

		// let any raise still scanning finish, with the result side open
		recv_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d raises and %0d queries, checked %0d query results",
			raises_sent, queries_sent, checked_results);
		$display("covered corners, clipped and empty rectangles, idle and stall mixes");
		if (fail_count == 0 && pending_results == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results outstanding", fail_count, pending_results);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
